[sv/msort_pkg.sv]
// Shared types for the merge sorter: controller commands and datapath status.
// No dependencies; used by msort_ctrl, msort_datapath and merge_sorter_core.
package msort_pkg;

  // One word of data, two's complement
  localparam int DataW = 32;

  // Commands from the controller to the datapath, one cycle each
  typedef struct packed {
    logic load;        // input word accepted: store it or drop it
    logic sort_start;  // first pass: run width 1, source bank A
    logic seg;         // set up the next pair of runs
    logic rd;          // read heads of both runs
    logic wr;          // write the smaller head, advance
    logic pass_next;   // double run width, swap banks
    logic out_start;   // rewind index for readout
    logic out_rd;      // read next sorted word
    logic out_load;    // move read word into output register
    logic clear;       // empty the store for the next set
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic sort_done;   // run width covers the whole set
    logic seg_end;     // the word being written is the last of its pair
    logic pass_end;    // the word being written or sent is the last of the set
    logic out_free;    // output register can take a word this cycle
  } sts_t;

endpackage

[sv/msort_ram.sv]
// Generic simple RAM: one write port, two registered read ports sharing an enable.
// No dependencies.
module msort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

[sv/msort_datapath.sv]
// Merge sorter datapath: two ping-pong banks, run indexes, output register.
// Depends on msort_pkg and msort_ram.
module msort_datapath #(
  parameter int DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  msort_pkg::cmd_t             cmd,
  output msort_pkg::sts_t             sts,
  input  logic [msort_pkg::DataW-1:0] in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [msort_pkg::DataW-1:0] out_data,
  output logic                        out_last,
  output logic                        out_drop
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);  // counts 0..DEPTH
  localparam int WW = CW + 1;             // run width, may reach past DEPTH
  localparam int SW = CW + 2;             // segment bound sums
  localparam int DW = msort_pkg::DataW;

  // Set state
  logic [CW-1:0] count;
  logic          drop;
  // Pass state
  logic [WW-1:0] width;
  logic          bank;     // 0: data in A, merge A->B
  logic [CW-1:0] base;
  logic [CW-1:0] i, j, k, mid, hi;

  logic          full;
  logic          take_i;
  logic [DW-1:0] a_rda, a_rdb, b_rda, b_rdb;
  logic [DW-1:0] head_i, head_j, merged;
  logic [SW-1:0] sum_w, sum_2w, n_ext;
  logic [CW-1:0] mid_new, hi_new;
  logic [CW-1:0] k_inc;
  logic          a_we, b_we, re;
  logic [AW-1:0] a_waddr, raddr_a;
  logic [DW-1:0] a_wdata;

  assign full = (count == CW'(DEPTH));

  // Segment bounds, clamped to the set size
  assign n_ext   = SW'(count);
  assign sum_w   = SW'(base) + SW'(width);
  assign sum_2w  = SW'(base) + SW'({width, 1'b0});
  assign mid_new = (sum_w  > n_ext) ? count : sum_w[CW-1:0];
  assign hi_new  = (sum_2w > n_ext) ? count : sum_2w[CW-1:0];

  // Merge decision, earlier run wins ties
  assign head_i = bank ? b_rda : a_rda;
  assign head_j = bank ? b_rdb : a_rdb;
  assign take_i = (i < mid) && ((j >= hi) || ($signed(head_i) <= $signed(head_j)));
  assign merged = take_i ? head_i : head_j;
  assign k_inc  = k + CW'(1);

  // Bank ports
  assign a_we    = (cmd.load && !full) || (cmd.wr && bank);
  assign b_we    = cmd.wr && !bank;
  assign a_waddr = cmd.load ? count[AW-1:0] : k[AW-1:0];
  assign a_wdata = cmd.load ? in_data : merged;
  assign re      = cmd.rd || cmd.out_rd;
  assign raddr_a = cmd.out_rd ? k[AW-1:0] : i[AW-1:0];

  msort_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_bank_a (
    .clk     (clk),
    .we      (a_we),
    .waddr   (a_waddr),
    .wdata   (a_wdata),
    .re      (re),
    .raddr_a (raddr_a),
    .raddr_b (j[AW-1:0]),
    .rdata_a (a_rda),
    .rdata_b (a_rdb)
  );

  msort_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_bank_b (
    .clk     (clk),
    .we      (b_we),
    .waddr   (k[AW-1:0]),
    .wdata   (merged),
    .re      (re),
    .raddr_a (raddr_a),
    .raddr_b (j[AW-1:0]),
    .rdata_a (b_rda),
    .rdata_b (b_rdb)
  );

  // Status
  assign sts.sort_done = (width >= WW'(count));
  assign sts.seg_end   = (k_inc == hi);
  assign sts.pass_end  = (k_inc == count);
  assign sts.out_free  = !out_valid || out_ready;

  // Set count and drop flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      drop  <= 1'b0;
    end else if (cmd.clear) begin
      count <= '0;
      drop  <= 1'b0;
    end else if (cmd.load) begin
      if (full) begin
        drop <= 1'b1;
      end else begin
        count <= count + CW'(1);
      end
    end
  end

  // Pass and run indexes
  always_ff @(posedge clk) begin
    if (cmd.sort_start) begin
      width <= WW'(1);
      bank  <= 1'b0;
      base  <= '0;
      k     <= '0;
    end
    if (cmd.pass_next) begin
      width <= {width[WW-2:0], 1'b0};
      bank  <= !bank;
      base  <= '0;
      k     <= '0;
    end
    if (cmd.seg) begin
      i    <= base;
      mid  <= mid_new;
      j    <= mid_new;
      hi   <= hi_new;
      base <= hi_new;
    end
    if (cmd.wr) begin
      k <= k_inc;
      if (take_i) begin
        i <= i + CW'(1);
      end else begin
        j <= j + CW'(1);
      end
    end
    if (cmd.out_start) begin
      k <= '0;
    end
    if (cmd.out_load) begin
      k <= k_inc;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= head_i;
      out_last <= sts.pass_end;
      out_drop <= drop;
    end
  end

endmodule

[sv/msort_ctrl.sv]
// Merge sorter controller: load, merge passes, readout sequencing.
// Depends on msort_pkg.
module msort_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_ready,
  output msort_pkg::cmd_t cmd,
  input  msort_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    S_LOAD,
    S_CHECK,
    S_SEG,
    S_RD,
    S_WR,
    S_NEXT,
    S_ORD,
    S_OLD
  } state_t;

  state_t state;
  logic   accept;

  assign in_ready = (state == S_LOAD);
  assign accept   = in_valid && in_ready;

  // Command decode
  always_comb begin
    cmd = '0;
    unique case (state)
      S_LOAD: begin
        cmd.load       = accept;
        cmd.sort_start = accept && in_last;
      end
      S_CHECK: cmd.out_start = sts.sort_done;
      S_SEG:   cmd.seg       = 1'b1;
      S_RD:    cmd.rd        = 1'b1;
      S_WR:    cmd.wr        = 1'b1;
      S_NEXT:  cmd.pass_next = 1'b1;
      S_ORD:   cmd.out_rd    = 1'b1;
      S_OLD: begin
        cmd.out_load = sts.out_free;
        cmd.clear    = sts.out_free && sts.pass_end;
      end
      default: cmd = '0;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (accept && in_last) begin
            state <= S_CHECK;
          end
        end
        S_CHECK: state <= sts.sort_done ? S_ORD : S_SEG;
        S_SEG:   state <= S_RD;
        S_RD:    state <= S_WR;
        S_WR: begin
          if (sts.pass_end) begin
            state <= S_NEXT;
          end else if (sts.seg_end) begin
            state <= S_SEG;
          end else begin
            state <= S_RD;
          end
        end
        S_NEXT:  state <= S_CHECK;
        S_ORD:   state <= S_OLD;
        S_OLD: begin
          if (sts.out_free) begin
            state <= sts.pass_end ? S_LOAD : S_ORD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

[sv/merge_sorter_core.sv]
// Merge sorter top level: stream ports, controller and datapath.
// Depends on msort_pkg, msort_ctrl, msort_datapath (and msort_ram below it).
//
// Use: send the words of one set on the s_ stream, the last one with s_tlast
// high. Up to DEPTH words are kept; further words of the set are dropped and
// every result of that set carries m_tuser high. After the last word the set
// is sorted ascending (signed, stable) by bottom-up merge passes between two
// banks, then sent on the m_ stream, m_tlast high on the last sorted word.
// s_tready is high only while loading, which takes one input word per cycle.
// Sorting takes ceil(log2(n)) merge passes; each word of a pass takes a bank
// read of both run heads, then a compare and write; each pair of runs first
// has its bounds set up, and each pass ends with a bank swap and a check of
// the run width. Readout reads each word from the bank, then moves it into
// the output register. The merge read/compare/write loop dominates the sort.
// The output register holds a word while m_tready is low; readout waits for
// it. Loading of the next set opens as soon as the last word of
// the set sits in the output register.
// Reset clears the set count, drop flag, valid and controller state; the
// banks keep no contents that matter.
module merge_sorter_core #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample_value
  input  logic        s_tlast,   // is_final
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] sorted_value
  output logic        m_tlast,   // end_of_run
  output logic        m_tuser    // [0] overflowed
);

  msort_pkg::cmd_t cmd;
  msort_pkg::sts_t sts;

  msort_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_last  (s_tlast),
    .in_ready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  msort_datapath #(.DEPTH(DEPTH)) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast),
    .out_drop  (m_tuser)
  );

endmodule

[verif/testbench.sv]
// Self-checking bench for merge_sorter_core: directed and random sets, stable-sort predictor, stream stalls.
// Depends on msort_pkg and merge_sorter_core (with msort_ctrl, msort_datapath, msort_ram).
module testbench;

  localparam int SetDepth = 64;
  localparam int RandomWords = 235;

  // One input word: the value and the end-of-set mark
  typedef struct packed {
    logic signed [msort_pkg::DataW-1:0] sample;
    logic                               final_word;
  } sample_word_t;

  // One sorted output word as the block should send it
  typedef struct packed {
    logic signed [msort_pkg::DataW-1:0] value;
    logic                               last_of_set;
    logic                               dropped;
  } sorted_word_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_tvalid = 1'b0;
  logic                        s_tready;
  logic [msort_pkg::DataW-1:0] s_tdata = '0;   // [31:0] sample_value
  logic                        s_tlast = 1'b0; // is_final
  logic                        m_tvalid;
  logic                        m_tready = 1'b0;
  logic [msort_pkg::DataW-1:0] m_tdata;        // [31:0] sorted_value
  logic                        m_tlast;        // end_of_run
  logic                        m_tuser;        // [0] overflowed

  // Words waiting to be sent, words sent so far
  sample_word_t pending_words[$];
  sample_word_t next_word;
  int           total_words = 0;
  int           accepted_words = 0;
  logic         in_fire = 1'b0;

  // Predictor state: the set being loaded and the sorted words still due
  logic signed [msort_pkg::DataW-1:0] set_vals[$];
  logic                               set_dropped = 1'b0;
  sorted_word_t                       sorted_due[$];

  int mismatches = 0;
  int src_gap = 0;
  int snk_stall = 0;
  int calm_left = 0;

  merge_sorter_core #(.DEPTH(SetDepth)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Idle length: mostly none or short, a few long, with calm stretches of no idling
  function automatic int pick_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random element: full range, a narrow band for ties, the extremes, and values just below the top
  function automatic logic signed [msort_pkg::DataW-1:0] rand_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return $urandom;
    if (r < 8) return $signed(32'($urandom_range(0, 8))) - 4;
    if (r == 8) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return 32'sh7fff_ffff - 32'($urandom_range(0, 3));
  endfunction

  task automatic add_word(input logic signed [msort_pkg::DataW-1:0] v, input logic fin);
    sample_word_t w;
    w.sample = v;
    w.final_word = fin;
    pending_words.push_back(w);
    total_words++;
  endtask

  // Predictor: collect the set, drop beyond depth, stable ascending sort on the final word
  task automatic take_sample(input sample_word_t w);
    logic signed [msort_pkg::DataW-1:0] key;
    sorted_word_t                       res;
    int                                 i;
    int                                 j;
    if (set_vals.size() < SetDepth) set_vals.push_back(w.sample);
    else set_dropped = 1'b1;
    if (w.final_word) begin
      // insertion sort: an element only moves past strictly larger ones, so ties keep order
      for (i = 1; i < set_vals.size(); i++) begin
        key = set_vals[i];
        j = i - 1;
        while (j >= 0 && set_vals[j] > key) begin
          set_vals[j + 1] = set_vals[j];
          j--;
        end
        set_vals[j + 1] = key;
      end
      for (i = 0; i < set_vals.size(); i++) begin
        res.value = set_vals[i];
        res.last_of_set = (i == set_vals.size() - 1);
        res.dropped = set_dropped;
        sorted_due.push_back(res);
      end
      set_vals.delete();
      set_dropped = 1'b0;
    end
  endtask

  // Input side driver and output side stall, both at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      m_tready <= 1'b0;
    end else begin
      if (s_tvalid && !in_fire) begin
        // word still waiting for the block
      end else if (src_gap > 0) begin
        s_tvalid <= 1'b0;
        src_gap <= src_gap - 1;
      end else if (pending_words.size() > 0) begin
        next_word = pending_words.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= next_word.sample;
        s_tlast <= next_word.final_word;
        src_gap <= pick_gap();
      end else begin
        s_tvalid <= 1'b0;
      end

      if (snk_stall > 0) begin
        m_tready <= 1'b0;
        snk_stall <= snk_stall - 1;
      end else begin
        m_tready <= 1'b1;
        snk_stall <= pick_gap();
      end
    end
  end

  // Accept-side prediction and result check at the rising edge
  always @(posedge clk) begin
    sorted_word_t want;
    sorted_word_t got;
    sample_word_t seen;
    in_fire <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      seen = '{sample: s_tdata, final_word: s_tlast};
      take_sample(seen);
      accepted_words++;
    end
    if (!rst && m_tvalid && m_tready) begin
      got = '{value: m_tdata, last_of_set: m_tlast, dropped: m_tuser};
      if (sorted_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: unexpected word value=%0d last=%0b overflow=%0b",
                   got.value, got.last_of_set, got.dropped);
      end else begin
        want = sorted_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b (value/last/overflow)",
                     want.value, want.last_of_set, want.dropped,
                     got.value, got.last_of_set, got.dropped);
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int set_idx;
    int set_len;
    int rand_total;
    int full_set;
    int over_set;
    int k;

    // single-word sets
    add_word(32'sd5, 1'b1);
    add_word(32'sh8000_0000, 1'b1);
    // extremes of the value range
    add_word(32'sh7fff_ffff, 1'b0);
    add_word(32'sh8000_0000, 1'b0);
    add_word(32'sd0, 1'b0);
    add_word(-32'sd1, 1'b0);
    add_word(32'sd1, 1'b1);
    // ties mixed with distinct values
    add_word(32'sd3, 1'b0);
    add_word(-32'sd2, 1'b0);
    add_word(32'sd3, 1'b0);
    add_word(-32'sd2, 1'b0);
    add_word(32'sd3, 1'b0);
    add_word(32'sh8000_0000, 1'b1);
    // reverse order
    for (k = 4; k >= -1; k--) add_word(k, k == -1);
    // two equal words
    add_word(32'sd7, 1'b0);
    add_word(32'sd7, 1'b1);

    // random sets, one exactly full and one that overflows the store
    full_set = $urandom_range(1, 4);
    over_set = $urandom_range(5, 8);
    rand_total = 0;
    set_idx = 0;
    while (rand_total < RandomWords || set_idx <= over_set) begin
      if (set_idx == full_set) set_len = SetDepth;
      else if (set_idx == over_set) set_len = SetDepth + $urandom_range(1, 6);
      else if ($urandom_range(0, 9) == 0) set_len = $urandom_range(13, 40);
      else set_len = $urandom_range(1, 12);
      for (k = 0; k < set_len; k++) add_word(rand_sample(), k == set_len - 1);
      rand_total += set_len;
      set_idx++;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (accepted_words < total_words) @(posedge clk);
    while (sorted_due.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);

    if (mismatches == 0 && sorted_due.size() == 0 && set_vals.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Timeout
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

[merge_sorter_core.f]
sv/msort_pkg.sv
sv/msort_ram.sv
sv/msort_datapath.sv
sv/msort_ctrl.sv
sv/merge_sorter_core.sv
verif/testbench.sv
